// File: rtl/multi_delimiter_tokenizer_unit_macros.svh
// Assertion macros for the multi-delimiter tokeniser.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef MULTI_DELIMITER_TOKENIZER_UNIT_MACROS_SVH
`define MULTI_DELIMITER_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MDT_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokeniser assertion failed");
`define MDT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokeniser assertion failed");
`else
`define MDT_ASSERT_IMPLIES(name, ante, cons)
`define MDT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/mdt_pkg.sv
// Package of the multi-delimiter tokeniser: sizes, codes and shared types.
// No dependencies.
package mdt_pkg;

  localparam int MAX_SEPS     = 4;
  localparam int MAX_SEP_LEN  = 4;
  localparam int COUNT_BITS   = 16;

  localparam int SEP_REGS     = 4;
  localparam int SEP_PRESENT  = (MAX_SEPS < SEP_REGS) ? MAX_SEPS : SEP_REGS;
  localparam int LEN_FIELD_W  = 3;
  localparam int LEN_REG_W    = SEP_REGS * LEN_FIELD_W;
  localparam int SEP_COUNT_W  = 3;
  localparam int SEP_TEXT_W   = 32;
  localparam int SEP_TEXT_BYTES = SEP_TEXT_W / 8;
  localparam int MAX_TOK_W    = 16;
  localparam int TOKEN_INDEX_W = 16;
  localparam int FILL_W       = $clog2(MAX_SEP_LEN + 1);
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;

  typedef logic [7:0]                              data_byte_t;
  typedef logic [FILL_W-1:0]                       fill_t;
  typedef logic [COUNT_BITS-1:0]                   count_t;
  typedef logic [TOKEN_INDEX_W-1:0]                token_index_t;
  typedef logic [SEP_PRESENT-1:0]                  sep_vec_t;
  typedef logic [SEP_PRESENT-1:0][7:0]             sep_bytes_t;
  typedef logic [MAX_SEP_LEN-1:0][SEP_PRESENT-1:0] eq_grid_t;
  typedef logic [CFG_INDEX_W-1:0]                  cfg_index_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_END  = 2'd1;
  localparam kind_t KIND_DONE = 2'd2;

  localparam cfg_index_t REG_SEP_COUNT   = 3'd0;
  localparam cfg_index_t REG_SEP_LENGTHS = 3'd1;
  localparam cfg_index_t REG_SEP_TEXT_0  = 3'd2;
  localparam cfg_index_t REG_SEP_TEXT_1  = 3'd3;
  localparam cfg_index_t REG_SEP_TEXT_2  = 3'd4;
  localparam cfg_index_t REG_SEP_TEXT_3  = 3'd5;
  localparam cfg_index_t REG_MAX_TOKENS  = 3'd6;

  typedef struct packed {
    logic  hit;
    fill_t len;
  } match_t;

endpackage

// File: rtl/mdt_in_if.sv
// Input stream interface of the multi-delimiter tokeniser.
// Depends on mdt_pkg.
interface mdt_in_if;
  logic                 valid;
  logic                 ready;
  mdt_pkg::data_byte_t  in_byte;
  logic                 byte_valid;
  logic                 end_of_string;

  modport source (output valid, in_byte, byte_valid, end_of_string, input ready);
  modport sink   (input valid, in_byte, byte_valid, end_of_string, output ready);
endinterface

// File: rtl/mdt_out_if.sv
// Result stream interface of the multi-delimiter tokeniser.
// Depends on mdt_pkg.
interface mdt_out_if;
  logic                  valid;
  logic                  ready;
  mdt_pkg::kind_t        kind;
  mdt_pkg::data_byte_t   out_byte;
  mdt_pkg::token_index_t token_index;
  logic                  last;

  modport source (output valid, kind, out_byte, token_index, last, input ready);
  modport sink   (input valid, kind, out_byte, token_index, last, output ready);
endinterface

// File: rtl/mdt_cell.sv
// One lookahead window cell: holds a byte, shifts it to its neighbour and
// compares it with the separator bytes for its position. Depends on mdt_pkg.
module mdt_cell (
  input  logic                clk,
  input  logic                load,
  input  logic                shift,
  input  mdt_pkg::data_byte_t load_byte,
  input  mdt_pkg::data_byte_t next_byte,
  input  mdt_pkg::sep_bytes_t sep_byte,
  output mdt_pkg::data_byte_t byte_q,
  output mdt_pkg::sep_vec_t   eq
);

  mdt_pkg::data_byte_t byte_r;
  mdt_pkg::data_byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = load_byte;
    end else if (shift) begin
      byte_nxt = next_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    for (int s = 0; s < mdt_pkg::SEP_PRESENT; s++) begin
      eq[s] = (byte_r == sep_byte[s]);
    end
  end

  assign byte_q = byte_r;

endmodule

// File: rtl/mdt_match.sv
// Separator selection: combines the per-cell compare bits into the first
// separator that matches in full. Depends on mdt_pkg.
module mdt_match (
  input  mdt_pkg::eq_grid_t                    eq_grid,
  input  mdt_pkg::fill_t                       fill,
  input  logic [mdt_pkg::SEP_COUNT_W-1:0]      sep_count,
  input  logic [mdt_pkg::LEN_REG_W-1:0]        sep_lengths,
  output mdt_pkg::match_t                      match
);

  always_comb begin
    logic [mdt_pkg::LEN_FIELD_W-1:0] field;
    mdt_pkg::fill_t                  len;
    logic                            ok;
    match = '0;
    // Walk from the highest separator down so the lowest one wins.
    for (int s = mdt_pkg::SEP_PRESENT - 1; s >= 0; s--) begin
      field = sep_lengths[mdt_pkg::LEN_FIELD_W*s +: mdt_pkg::LEN_FIELD_W];
      if (int'(field) > mdt_pkg::MAX_SEP_LEN) begin
        len = mdt_pkg::fill_t'(mdt_pkg::MAX_SEP_LEN);
      end else begin
        len = mdt_pkg::fill_t'(field);
      end
      ok = (s < int'(sep_count)) && (len != '0) && (len <= fill);
      for (int k = 0; k < mdt_pkg::MAX_SEP_LEN; k++) begin
        if ((k < int'(len)) && !eq_grid[k][s]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        match.hit = 1'b1;
        match.len = len;
      end
    end
  end

endmodule

// File: rtl/multi_delimiter_tokenizer_unit.sv
// Multi-delimiter tokeniser top level: configuration registers, window cell
// chain, separator selection, sequencer and result register.
// Depends on mdt_pkg, mdt_in_if, mdt_out_if, mdt_cell and mdt_match.
//
// A string enters one byte per transaction on in_chan; end_of_string closes
// it, and byte_valid low marks an end transaction that carries no byte.
// Results leave on out_chan as token bytes, token-end markers and a final
// string-done marker; last is set on the final result of each transaction.
// Separators and the token limit are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, as the
// block itself does not enforce it. A byte that fills the four-byte window
// is decided in the DECIDE phase once the receiver can take a result, and
// any result is registered in the output register. A separator match is
// consumed by that decision's shift and then one SHIFT step per further
// separator byte, as the window chain moves one byte per cycle. An end of
// string decides each remaining window byte, then emits the closing markers
// in the CLOSE and DONE phases. Input is accepted only in the idle phase.
// Reset empties the window and restores one comma separator and a token
// limit of 65535. When the receiver stalls, the result register holds its
// transaction and the block keeps accepting input until the window fills
// or a string ends, as every decision and closing step waits for it.
`include "multi_delimiter_tokenizer_unit_macros.svh"

module multi_delimiter_tokenizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  mdt_in_if.sink                             in_chan,
  mdt_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  mdt_pkg::cfg_index_t                cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DECIDE = 3'd1;
  localparam logic [2:0] PH_SHIFT  = 3'd2;
  localparam logic [2:0] PH_CLOSE  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [mdt_pkg::SEP_REGS-1:0][mdt_pkg::SEP_TEXT_W-1:0] SEP_TEXT_RST =
    {{((mdt_pkg::SEP_REGS - 1) * mdt_pkg::SEP_TEXT_W){1'b0}}, mdt_pkg::SEP_TEXT_W'(44)};

  // Configuration registers.
  logic [mdt_pkg::SEP_COUNT_W-1:0]                      sep_count_r, sep_count_nxt;
  logic [mdt_pkg::LEN_REG_W-1:0]                        sep_lengths_r, sep_lengths_nxt;
  logic [mdt_pkg::SEP_REGS-1:0][mdt_pkg::SEP_TEXT_W-1:0] sep_text_r, sep_text_nxt;
  logic [mdt_pkg::MAX_TOK_W-1:0]                        max_tokens_r, max_tokens_nxt;

  // Sequencer state.
  logic [2:0]          phase_r, phase_nxt;
  mdt_pkg::fill_t      fill_r, fill_nxt;
  mdt_pkg::fill_t      shift_left_r, shift_left_nxt;
  logic                token_open_r, token_open_nxt;
  mdt_pkg::count_t     tokens_done_r, tokens_done_nxt;
  logic                discarding_r, discarding_nxt;
  logic                eos_r, eos_nxt;

  // Result register.
  logic                  out_vld_r, out_vld_nxt;
  mdt_pkg::kind_t        out_kind_r, out_kind_nxt;
  mdt_pkg::data_byte_t   out_byte_r, out_byte_nxt;
  mdt_pkg::token_index_t out_index_r, out_index_nxt;
  logic                  out_last_r, out_last_nxt;

  // Window chain.
  mdt_pkg::data_byte_t cell_byte [mdt_pkg::MAX_SEP_LEN];
  mdt_pkg::data_byte_t next_byte [mdt_pkg::MAX_SEP_LEN];
  mdt_pkg::sep_bytes_t cell_sep  [mdt_pkg::MAX_SEP_LEN];
  mdt_pkg::eq_grid_t   eq_grid;
  mdt_pkg::match_t     match;

  logic                load_en;
  logic                shift_en;
  logic                can_push;
  logic                over_limit;
  logic                go_after;
  logic                emit;
  mdt_pkg::kind_t      emit_kind;
  mdt_pkg::data_byte_t emit_byte;
  mdt_pkg::count_t     emit_index;
  mdt_pkg::fill_t      consume;

  genvar k, s;
  generate
    for (k = 0; k < mdt_pkg::MAX_SEP_LEN; k++) begin : g_cell
      if (k < mdt_pkg::MAX_SEP_LEN - 1) begin : g_link
        assign next_byte[k] = cell_byte[k+1];
      end else begin : g_tail
        assign next_byte[k] = '0;
      end
      for (s = 0; s < mdt_pkg::SEP_PRESENT; s++) begin : g_sep
        if (k < mdt_pkg::SEP_TEXT_BYTES) begin : g_text
          assign cell_sep[k][s] = sep_text_r[s][8*k +: 8];
        end else begin : g_pad
          assign cell_sep[k][s] = '0;
        end
      end
      mdt_cell u_cell (
        .clk       (clk),
        .load      (load_en && (fill_r == mdt_pkg::fill_t'(k))),
        .shift     (shift_en),
        .load_byte (in_chan.in_byte),
        .next_byte (next_byte[k]),
        .sep_byte  (cell_sep[k]),
        .byte_q    (cell_byte[k]),
        .eq        (eq_grid[k])
      );
    end
  endgenerate

  mdt_match u_match (
    .eq_grid     (eq_grid),
    .fill        (fill_r),
    .sep_count   (sep_count_r),
    .sep_lengths (sep_lengths_r),
    .match       (match)
  );

  assign in_chan.ready = (phase_r == PH_IDLE);
  assign can_push      = !out_vld_r || out_chan.ready;
  assign over_limit    = (32'(tokens_done_r) >= 32'(max_tokens_r));

  always_comb begin
    sep_count_nxt   = sep_count_r;
    sep_lengths_nxt = sep_lengths_r;
    sep_text_nxt    = sep_text_r;
    max_tokens_nxt  = max_tokens_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mdt_pkg::REG_SEP_COUNT:   sep_count_nxt   = cfg_wdata[mdt_pkg::SEP_COUNT_W-1:0];
        mdt_pkg::REG_SEP_LENGTHS: sep_lengths_nxt = cfg_wdata[mdt_pkg::LEN_REG_W-1:0];
        mdt_pkg::REG_SEP_TEXT_0:  sep_text_nxt[0] = cfg_wdata[mdt_pkg::SEP_TEXT_W-1:0];
        mdt_pkg::REG_SEP_TEXT_1:  sep_text_nxt[1] = cfg_wdata[mdt_pkg::SEP_TEXT_W-1:0];
        mdt_pkg::REG_SEP_TEXT_2:  sep_text_nxt[2] = cfg_wdata[mdt_pkg::SEP_TEXT_W-1:0];
        mdt_pkg::REG_SEP_TEXT_3:  sep_text_nxt[3] = cfg_wdata[mdt_pkg::SEP_TEXT_W-1:0];
        mdt_pkg::REG_MAX_TOKENS:  max_tokens_nxt  = cfg_wdata[mdt_pkg::MAX_TOK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    fill_nxt        = fill_r;
    shift_left_nxt  = shift_left_r;
    token_open_nxt  = token_open_r;
    tokens_done_nxt = tokens_done_r;
    discarding_nxt  = discarding_r;
    eos_nxt         = eos_r;
    load_en         = 1'b0;
    shift_en        = 1'b0;
    go_after        = 1'b0;
    emit            = 1'b0;
    emit_kind       = mdt_pkg::KIND_BYTE;
    emit_byte       = '0;
    emit_index      = tokens_done_r;
    consume         = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_chan.valid) begin
          eos_nxt = in_chan.end_of_string;
          if (over_limit) begin
            discarding_nxt = 1'b1;
            fill_nxt       = '0;
            token_open_nxt = 1'b0;
          end
          if (in_chan.byte_valid && !discarding_nxt) begin
            load_en  = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          if (load_en && (int'(fill_nxt) == mdt_pkg::MAX_SEP_LEN)) begin
            phase_nxt = PH_DECIDE;
          end else begin
            go_after = 1'b1;
          end
        end
      end
      PH_DECIDE: begin
        if (can_push) begin
          if (match.hit) begin
            if (token_open_r) begin
              emit            = 1'b1;
              emit_kind       = mdt_pkg::KIND_END;
              tokens_done_nxt = mdt_pkg::count_t'(tokens_done_r + 1'b1);
              token_open_nxt  = 1'b0;
              if (32'(tokens_done_nxt) >= 32'(max_tokens_r)) begin
                discarding_nxt = 1'b1;
                fill_nxt       = '0;
                go_after       = 1'b1;
              end else begin
                consume = match.len;
              end
            end else begin
              consume = match.len;
            end
          end else begin
            emit           = 1'b1;
            emit_kind      = mdt_pkg::KIND_BYTE;
            emit_byte      = cell_byte[0];
            token_open_nxt = 1'b1;
            consume        = mdt_pkg::fill_t'(1);
          end
          if (consume != '0) begin
            shift_en = 1'b1;
            fill_nxt = fill_r - 1'b1;
            if (consume == mdt_pkg::fill_t'(1)) begin
              go_after = 1'b1;
            end else begin
              shift_left_nxt = consume - 1'b1;
              phase_nxt      = PH_SHIFT;
            end
          end
        end
      end
      PH_SHIFT: begin
        shift_en       = 1'b1;
        fill_nxt       = fill_r - 1'b1;
        shift_left_nxt = shift_left_r - 1'b1;
        if (shift_left_r == mdt_pkg::fill_t'(1)) begin
          go_after = 1'b1;
        end
      end
      PH_CLOSE: begin
        if (can_push) begin
          if (!discarding_r) begin
            if (token_open_r) begin
              emit            = 1'b1;
              emit_kind       = mdt_pkg::KIND_END;
              tokens_done_nxt = mdt_pkg::count_t'(tokens_done_r + 1'b1);
            end else if ((sep_count_r == '0) && (tokens_done_r == '0)) begin
              // An empty string with no separators still yields one token.
              emit            = 1'b1;
              emit_kind       = mdt_pkg::KIND_END;
              tokens_done_nxt = mdt_pkg::count_t'(1);
            end
          end
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        if (can_push) begin
          emit            = 1'b1;
          emit_kind       = mdt_pkg::KIND_DONE;
          fill_nxt        = '0;
          token_open_nxt  = 1'b0;
          tokens_done_nxt = '0;
          discarding_nxt  = 1'b0;
          eos_nxt         = 1'b0;
          phase_nxt       = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (go_after) begin
      if (eos_nxt) begin
        phase_nxt = ((fill_nxt != '0) && !discarding_nxt) ? PH_DECIDE : PH_CLOSE;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_vld_nxt   = 1'b1;
      out_kind_nxt  = emit_kind;
      out_byte_nxt  = emit_byte;
      out_index_nxt = mdt_pkg::token_index_t'(emit_index);
      out_last_nxt  = !eos_r || (emit_kind == mdt_pkg::KIND_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_count_r   <= mdt_pkg::SEP_COUNT_W'(1);
      sep_lengths_r <= mdt_pkg::LEN_REG_W'(585);
      sep_text_r    <= SEP_TEXT_RST;
      max_tokens_r  <= '1;
      phase_r       <= PH_IDLE;
      fill_r        <= '0;
      shift_left_r  <= '0;
      token_open_r  <= 1'b0;
      tokens_done_r <= '0;
      discarding_r  <= 1'b0;
      eos_r         <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      sep_count_r   <= sep_count_nxt;
      sep_lengths_r <= sep_lengths_nxt;
      sep_text_r    <= sep_text_nxt;
      max_tokens_r  <= max_tokens_nxt;
      phase_r       <= phase_nxt;
      fill_r        <= fill_nxt;
      shift_left_r  <= shift_left_nxt;
      token_open_r  <= token_open_nxt;
      tokens_done_r <= tokens_done_nxt;
      discarding_r  <= discarding_nxt;
      eos_r         <= eos_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.token_index = out_index_r;
  assign out_chan.last        = out_last_r;

  `MDT_ASSERT_IMPLIES(a_decide_has_bytes, phase_r == PH_DECIDE, fill_r != '0 && !discarding_r)
  `MDT_ASSERT_IMPLIES(a_done_is_last, out_vld_r && out_kind_r == mdt_pkg::KIND_DONE, out_last_r)
  `MDT_ASSERT_NEXT(a_done_clears, phase_r == PH_DONE && can_push, phase_r == PH_IDLE)
  `MDT_ASSERT_NEXT(a_zeroed, phase_r == PH_DONE && can_push, fill_r == '0 && tokens_done_r == '0)

endmodule
